// ----- hw/rtl/segregated_free_list_allocator_defines.svh -----
// Assertion helpers; expect clk_i and rst_ni in the including module.
`ifndef SEGREGATED_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SEGREGATED_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication.
`define SFLA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SFLA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sfla_pkg.sv -----
`timescale 1ns / 1ps

package sfla_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned NUM_CLASSES = 5;
  localparam int unsigned CLS_W       = 3;
  localparam int unsigned MIN_SHIFT   = 6;
  localparam int unsigned MIN_CHUNK   = 64;
  localparam int unsigned MAX_CHUNK   = 1024;
  localparam int unsigned KB_SHIFT    = 10;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned SLABK_W     = 7;
  localparam int unsigned SLABK_MAX   = 64;
  localparam int unsigned LO_W        = 9;
  localparam int unsigned LINK_DEPTH  = 1984;
  localparam int unsigned LINK_AW     = 11;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned TOTAL_W     = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SIZE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_CLASS_EMPTY  = 3'd2,
    ST_NULL_FREE    = 3'd3,
    ST_OUT_OF_RANGE = 3'd4,
    ST_MISALIGNED   = 3'd5
  } status_e;

  // Start of each slab, and the end of the last one, in KiB.
  typedef logic [NUM_CLASSES:0][LO_W-1:0] lo_arr_t;

  typedef struct packed {
    logic             is_free;
    status_e          status;
    logic [CLS_W-1:0] cls;
    logic [IDX_W-1:0] idx;
  } item_t;

  // First link slot of a class: capacities of the lower classes summed.
  function automatic logic [LINK_AW-1:0] link_base(input logic [CLS_W-1:0] cls);
    logic [LINK_AW-1:0] b;
    case (cls)
      3'd0:    b = 11'd0;
      3'd1:    b = 11'd1024;
      3'd2:    b = 11'd1536;
      3'd3:    b = 11'd1792;
      3'd4:    b = 11'd1920;
      default: b = 11'd0;
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/sfla_fifo.sv -----
`timescale 1ns / 1ps
`include "segregated_free_list_allocator_defines.svh"

module sfla_fifo import sfla_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o
);

  item_t      mem_q [Q_DEPTH];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(Q_DEPTH));
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `SFLA_ASSERT_IMP(a_pop_nonempty, pop_i, cnt_q != 2'd0, "pop from empty queue")
  `SFLA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= 2'(Q_DEPTH), "queue count overflow")
  `SFLA_ASSERT_NXT(a_push_fills, push_i && !pop_i, cnt_q != 2'd0, "pushed beat lost")

endmodule

// ----- hw/rtl/sfla_front.sv -----
`timescale 1ns / 1ps

module sfla_front import sfla_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  input  logic [SIZE_W-1:0] alloc_size_i,
  input  logic [ADDR_W-1:0] free_addr_i,
  input  logic [ADDR_W-1:0] base_i,
  input  lo_arr_t           lo_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output item_t             item_o
);

  logic [ADDR_W-1:0]          off;
  logic [ADDR_W-KB_SHIFT-1:0] off_k;
  logic [CLS_W-1:0]           f_cls, a_cls;
  logic [5:0]                 slab_off_hi;
  logic [15:0]                slab_off;
  logic [KB_SHIFT-1:0]        align_mask;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign off   = free_addr_i - base_i;
  assign off_k = off[ADDR_W-1:KB_SHIFT];

  always_comb begin
    f_cls = '0;
    for (int k = 1; k < NUM_CLASSES; k++) begin
      if (off_k >= (ADDR_W-KB_SHIFT)'(lo_i[k])) f_cls = CLS_W'(k);
    end
    a_cls = '0;
    for (int k = 0; k < NUM_CLASSES - 1; k++) begin
      if (alloc_size_i > SIZE_W'(MIN_CHUNK << k)) a_cls = CLS_W'(k + 1);
    end
  end

  assign slab_off_hi = off[15:KB_SHIFT] - lo_i[f_cls][5:0];
  assign slab_off    = {slab_off_hi, off[KB_SHIFT-1:0]};
  assign align_mask  = KB_SHIFT'((11'(MIN_CHUNK) << f_cls) - 11'd1);

  always_comb begin
    item_o.is_free = req_type_i;
    item_o.status  = ST_OK;
    item_o.cls     = '0;
    item_o.idx     = '0;
    if (!req_type_i) begin
      if (alloc_size_i > SIZE_W'(MAX_CHUNK)) begin
        item_o.status = ST_TOO_LARGE;
      end else begin
        item_o.cls = a_cls;
      end
    end else if (free_addr_i == '0) begin
      item_o.status = ST_NULL_FREE;
    end else if (off_k >= (ADDR_W-KB_SHIFT)'(lo_i[NUM_CLASSES])) begin
      item_o.status = ST_OUT_OF_RANGE;
    end else if ((off[KB_SHIFT-1:0] & align_mask) != '0) begin
      item_o.status = ST_MISALIGNED;
    end else begin
      item_o.cls = f_cls;
      item_o.idx = IDX_W'(slab_off >> (MIN_SHIFT + f_cls));
    end
  end

endmodule

// ----- hw/rtl/sfla_back.sv -----
`timescale 1ns / 1ps
`include "segregated_free_list_allocator_defines.svh"

module sfla_back import sfla_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic [ADDR_W-1:0]  base_i,
  input  logic [SLABK_W-1:0] slab_k_i,
  input  lo_arr_t            lo_i,
  input  logic               q_valid_i,
  input  item_t              q_item_i,
  output logic               q_pop_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [ADDR_W-1:0]  out_addr_o,
  output status_e            out_status_o
);

  typedef enum logic {S_IDLE, S_LINK} state_e;

  state_e             state_q;
  logic [IDX_W:0]     head_q [NUM_CLASSES];
  logic [CNT_W-1:0]   cnt_q  [NUM_CLASSES];
  logic [CLS_W-1:0]   pend_cls_q;
  logic               out_valid_q;
  logic [ADDR_W-1:0]  out_addr_q;
  status_e            out_status_q;

  logic [IDX_W:0]     link_mem [LINK_DEPTH];
  logic [IDX_W:0]     link_rdata_q;

  logic               take, ok, is_alloc, is_pop, is_fresh;
  logic [CLS_W-1:0]   cls;
  logic [IDX_W:0]     head;
  logic [CNT_W-1:0]   cnt, capacity;
  logic [IDX_W-1:0]   grant_idx;
  logic [LINK_AW-1:0] link_addr;
  logic               link_wr, link_rd;
  logic [ADDR_W-1:0]  chunk_off, res_addr;
  status_e            res_status;

  assign take = (state_q == S_IDLE) && q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = take;

  assign cls       = q_item_i.cls;
  assign head      = head_q[cls];
  assign cnt       = cnt_q[cls];
  assign capacity  = CNT_W'({slab_k_i, 4'b0}) >> cls;
  assign ok        = (q_item_i.status == ST_OK);
  assign is_alloc  = ok && !q_item_i.is_free;
  assign is_pop    = is_alloc && head[IDX_W];
  assign is_fresh  = is_alloc && !head[IDX_W] && (cnt < capacity);
  assign grant_idx = head[IDX_W] ? head[IDX_W-1:0] : cnt[IDX_W-1:0];

  assign link_addr = link_base(cls) + LINK_AW'(q_item_i.is_free ? q_item_i.idx : grant_idx);
  assign link_wr   = take && ok && q_item_i.is_free;
  assign link_rd   = take && is_pop;

  assign chunk_off = ADDR_W'({lo_i[cls], KB_SHIFT'(0)})
                   + (ADDR_W'(grant_idx) << (MIN_SHIFT + cls));

  always_comb begin
    res_addr   = '0;
    res_status = q_item_i.status;
    if (is_pop || is_fresh) begin
      res_addr = base_i + chunk_off;
    end else if (is_alloc) begin
      res_status = ST_CLASS_EMPTY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_wr) begin
      link_mem[link_addr] <= head;
    end
    if (link_rd) begin
      link_rdata_q <= link_mem[link_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_cls_q   <= '0;
      out_valid_q  <= 1'b0;
      out_addr_q   <= '0;
      out_status_q <= ST_OK;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
    end else begin
      if (take && !clear_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (clear_i) begin
        state_q <= S_IDLE;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          head_q[c] <= '0;
          cnt_q[c]  <= '0;
        end
      end else begin
        case (state_q)
          S_IDLE: begin
            if (take) begin
              out_addr_q   <= res_addr;
              out_status_q <= res_status;
              pend_cls_q   <= cls;
              if (link_wr) head_q[cls] <= {1'b1, q_item_i.idx};
              if (is_fresh) cnt_q[cls] <= cnt + CNT_W'(1);
              if (is_pop) state_q <= S_LINK;
            end
          end
          S_LINK: begin
            head_q[pend_cls_q] <= link_rdata_q;
            state_q            <= S_IDLE;
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_addr_o   = out_addr_q;
  assign out_status_o = out_status_q;

  `SFLA_ASSERT_NXT(a_link_one_cycle, state_q == S_LINK, state_q == S_IDLE, "link wait overran")
  `SFLA_ASSERT_IMP(a_link_has_result, state_q == S_LINK, out_valid_q, "pop result missing")
  `SFLA_ASSERT_NXT(a_clear_heads, clear_i, !head_q[0][IDX_W] && !head_q[NUM_CLASSES-1][IDX_W],
                   "heads survive clear")

endmodule

// ----- hw/rtl/segregated_free_list_allocator.sv -----
`timescale 1ns / 1ps
// Segregated free-list allocator, five power-of-two classes of 64 to 1024 bytes.
// Requests arrive on the s_axis channel: tuser is the request kind (0 allocate,
// 1 free), tdata carries the size and the freed address. One result beat per
// request leaves on m_axis: the chunk address (0 when none) and a status code.
// The config port sets the region base and size; every write also empties all
// classes. Write it only while no request is in flight.
// A request is classified in the cycle it is accepted and queued in a two-entry
// queue. The back end takes one queued request per cycle while it is idle and its
// result register is free or being drained; an allocate that pops a freed chunk
// then waits in a link state for the registered read of the link memory, and the
// result beat is registered as the back end takes the request.
// A stalled result holds in the output register; accepts continue until the
// queue fills. Reset clears all classes at once; the link memory needs no
// clearing pass since a link is read only after it was written.
module segregated_free_list_allocator import sfla_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // alloc_size[15:0], free_addr[47:16]
  input  logic                  s_axis_tuser,  // req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // result_addr[31:0], status[34:32], zero
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // floor(x / 5) as (x * 205) >> 10, exact for x below 1024
  localparam logic [16:0] DIV5_MUL = 17'd205;

  logic [ADDR_W-MIN_SHIFT-1:0] base_q;
  logic [SLABK_W-1:0]          slab_k_q, slab_k_d;
  logic [ADDR_W-1:0]           base;
  lo_arr_t                     lo;
  logic [16:0]                 div_prod;
  logic [SLABK_W-1:0]          div_quot;

  logic    q_push, q_pop, q_full, q_valid;
  item_t   item_in, item_out;
  logic [ADDR_W-1:0] res_addr;
  status_e res_status;

  assign div_prod = 17'(cfg_wdata_i[TOTAL_W-1:KB_SHIFT]) * DIV5_MUL;
  assign div_quot = div_prod[16:KB_SHIFT];
  assign slab_k_d = (div_quot > SLABK_W'(SLABK_MAX)) ? SLABK_W'(SLABK_MAX) : div_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      slab_k_q <= SLABK_W'(SLABK_MAX);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_ADDR:  base_q   <= cfg_wdata_i[ADDR_W-1:MIN_SHIFT];
        CFG_TOTAL_SIZE: slab_k_q <= slab_k_d;
        default:        base_q   <= base_q;
      endcase
    end
  end

  assign base = {base_q, MIN_SHIFT'(0)};

  always_comb begin
    for (int k = 0; k <= NUM_CLASSES; k++) begin
      lo[k] = LO_W'(LO_W'(slab_k_q) * LO_W'(k));
    end
  end

  sfla_front u_front (
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .alloc_size_i (s_axis_tdata[15:0]),
    .free_addr_i  (s_axis_tdata[47:16]),
    .base_i       (base),
    .lo_i         (lo),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .item_o       (item_in)
  );

  sfla_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (item_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (item_out)
  );

  sfla_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (cfg_we_i),
    .base_i       (base),
    .slab_k_i     (slab_k_q),
    .lo_i         (lo),
    .q_valid_i    (q_valid),
    .q_item_i     (item_out),
    .q_pop_o      (q_pop),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_addr_o   (res_addr),
    .out_status_o (res_status)
  );

  assign m_axis_tdata = {5'b0, res_status, res_addr};

endmodule

// ----- test/segregated_free_list_allocator_test.sv -----
`timescale 1ns / 1ps

module segregated_free_list_allocator_test;
  import sfla_pkg::*;

  localparam int unsigned SLAB_CAP    = 65536;
  localparam int          STUCK_LIMIT = 2000;
  localparam int          EMPTY       = -1;

  typedef struct packed {
    logic        is_free;
    logic [15:0] size;
    logic [31:0] addr;
  } alloc_req_t;

  typedef struct packed {
    logic [31:0] addr;
    status_e     status;
  } alloc_reply_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata  = '0;  // alloc_size[15:0], free_addr[47:16]
  logic                  s_axis_tuser  = 1'b0;  // req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;  // result_addr[31:0], status[34:32], zero
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  alloc_req_t   request_q[$];
  alloc_reply_t chunk_replies[$];

  logic [31:0] base_r  = 32'd0;
  logic [18:0] total_r = 19'd327680;
  int          freed_top[NUM_CLASSES];
  int          fresh_used[NUM_CLASSES];
  int          link_mem[LINK_DEPTH];
  int          issued_allocs[NUM_CLASSES];

  int  src_idle_pct = 14;
  int  snk_idle_pct = 52;
  logic in_taken    = 1'b0;
  int  stuck_cycles = 0;
  int  mismatches   = 0;

  segregated_free_list_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] slab_bytes(input logic [18:0] total);
    logic [31:0] s;
    s = total / NUM_CLASSES;
    s = s - s % MAX_CHUNK;
    if (s > SLAB_CAP) s = SLAB_CAP;
    return s;
  endfunction

  function automatic int first_slot(input int cls);
    int b;
    b = 0;
    for (int k = 0; k < cls; k++) b += SLAB_CAP >> (MIN_SHIFT + k);
    return b;
  endfunction

  function automatic void clear_classes();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      freed_top[c]     = EMPTY;
      fresh_used[c]    = 0;
      issued_allocs[c] = 0;
    end
  endfunction

  function automatic alloc_reply_t serve_request(input alloc_req_t r);
    alloc_reply_t o;
    logic [31:0]  base;
    logic [31:0]  slab;
    logic [31:0]  off;
    logic [31:0]  slab_off;
    logic [31:0]  csize;
    int           c;
    int           idx;
    int           slot;
    base     = {base_r[31:6], 6'd0};
    slab     = slab_bytes(total_r);
    o.addr   = '0;
    o.status = ST_OK;
    if (!r.is_free) begin
      if (r.size > MAX_CHUNK) begin
        o.status = ST_TOO_LARGE;
      end else begin
        c = 0;
        while (c + 1 < NUM_CLASSES && (MIN_CHUNK << c) < r.size) c++;
        idx = EMPTY;
        if (freed_top[c] != EMPTY) begin
          idx          = freed_top[c];
          freed_top[c] = link_mem[first_slot(c) + idx];
        end else if (fresh_used[c] < (slab >> (MIN_SHIFT + c))) begin
          idx = fresh_used[c];
          fresh_used[c]++;
        end else begin
          o.status = ST_CLASS_EMPTY;
        end
        if (idx != EMPTY) begin
          o.addr = base + slab * 32'(c) + (32'(idx) << (MIN_SHIFT + c));
        end
      end
    end else if (r.addr == 32'd0) begin
      o.status = ST_NULL_FREE;
    end else begin
      off = r.addr - base;
      c   = (slab == 0) ? NUM_CLASSES : int'(off / slab);
      if (c >= NUM_CLASSES) begin
        o.status = ST_OUT_OF_RANGE;
      end else begin
        slab_off = off - slab * 32'(c);
        csize    = MIN_CHUNK << c;
        if ((slab_off & (csize - 1)) != 0) begin
          o.status = ST_MISALIGNED;
        end else begin
          idx  = int'(slab_off >> (MIN_SHIFT + c));
          slot = first_slot(c) + idx;
          if (slot < LINK_DEPTH) begin
            link_mem[slot] = freed_top[c];
            freed_top[c]   = idx;
          end
        end
      end
    end
    return o;
  endfunction

  always @(negedge clk_i) begin : drive_requests
    alloc_req_t r;
    if (!s_axis_tvalid || in_taken) begin
      if (request_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        r = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.is_free;
        s_axis_tdata  <= {r.addr, r.size};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin : watch_replies
    alloc_reply_t want;
    logic         in_hs;
    logic         out_hs;
    in_hs  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_hs = rst_ni && m_axis_tvalid && m_axis_tready;
    if (out_hs) begin
      if (chunk_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected reply beat, actual addr %h status %0d",
                 $realtime, m_axis_tdata[31:0], m_axis_tdata[34:32]);
      end else begin
        want = chunk_replies.pop_front();
        if (m_axis_tdata[31:0] !== want.addr) begin
          mismatches++;
          $display("%0t: result_addr expected %h actual %h",
                   $realtime, want.addr, m_axis_tdata[31:0]);
        end
        if (m_axis_tdata[34:32] !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d",
                   $realtime, want.status, m_axis_tdata[34:32]);
        end
      end
    end
    if (in_hs) begin
      chunk_replies.push_back(serve_request({s_axis_tuser, s_axis_tdata[15:0],
                                             s_axis_tdata[47:16]}));
    end
    in_taken     <= in_hs;
    stuck_cycles <= (in_hs || out_hs) ? 0 : stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("segregated_free_list_allocator_test: done, errors");
    $finish;
  end

  function automatic void push_req(input logic is_free, input logic [15:0] size,
                                   input logic [31:0] addr);
    alloc_req_t r;
    r.is_free = is_free;
    r.size    = is_free ? 16'($urandom) : size;
    r.addr    = is_free ? addr : $urandom;
    request_q.push_back(r);
  endfunction

  task automatic drain();
    while (request_q.size() != 0 || s_axis_tvalid || chunk_replies.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_BASE_ADDR) base_r = val;
    else total_r = val[18:0];
    clear_classes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic reconfigure(input logic [31:0] base, input logic [18:0] total);
    drain();
    write_reg(CFG_BASE_ADDR, base);
    write_reg(CFG_TOTAL_SIZE, 32'(total));
  endtask

  task automatic random_burst(input int n);
    logic [31:0] base;
    logic [31:0] slab;
    int          pick;
    int          c;
    int          hi;
    int          k;
    base = {base_r[31:6], 6'd0};
    slab = slab_bytes(total_r);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      c    = $urandom_range(NUM_CLASSES - 1);
      if (pick < 45) begin
        if (c == 0) push_req(1'b0, 16'($urandom_range(MIN_CHUNK)), '0);
        else push_req(1'b0, 16'($urandom_range(MIN_CHUNK << c, (MIN_CHUNK << (c - 1)) + 1)),
                      '0);
        issued_allocs[c]++;
      end else if (pick < 85) begin
        hi = slab >> (MIN_SHIFT + c);
        if (issued_allocs[c] < hi) hi = issued_allocs[c];
        k = (hi == 0) ? 0 : $urandom_range(hi - 1);
        push_req(1'b1, '0, base + slab * 32'(c) + (32'(k) << (MIN_SHIFT + c)));
      end else if (pick < 90) begin
        push_req(1'b0, (pick & 1) ? 16'($urandom) : 16'($urandom_range(1100)), '0);
      end else if (pick < 97) begin
        push_req(1'b1, '0, (pick & 1) ? $urandom
                                      : base + 32'($urandom_range(slab * 5 + 100)));
      end else begin
        push_req(1'b1, '0, 32'd0);
      end
    end
  endtask

  initial begin
    clear_classes();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero base, full-size region
    push_req(1'b0, 16'd0, '0);
    push_req(1'b0, 16'd1, '0);
    push_req(1'b0, 16'd64, '0);
    push_req(1'b0, 16'd65, '0);
    push_req(1'b0, 16'd128, '0);
    push_req(1'b0, 16'd129, '0);
    push_req(1'b0, 16'd256, '0);
    push_req(1'b0, 16'd257, '0);
    push_req(1'b0, 16'd512, '0);
    push_req(1'b0, 16'd513, '0);
    push_req(1'b0, 16'd1024, '0);
    push_req(1'b0, 16'd1025, '0);
    push_req(1'b0, 16'hFFFF, '0);
    push_req(1'b1, '0, 32'd0);
    push_req(1'b1, '0, 32'd64);
    push_req(1'b0, 16'd64, '0);
    push_req(1'b1, '0, 32'd64);
    push_req(1'b1, '0, 32'd64);
    push_req(1'b0, 16'd1, '0);
    push_req(1'b0, 16'd1, '0);
    push_req(1'b1, '0, 32'hFFFF_FFFF);
    push_req(1'b1, '0, 32'd65536 + 32'd32);
    push_req(1'b1, '0, 32'd5 * 32'd65536);
    push_req(1'b1, '0, 32'd4 * 32'd65536);
    push_req(1'b0, 16'd1000, '0);

    reconfigure(32'hFFFF_FFFF, 19'd327680);
    random_burst(250);
    reconfigure(32'h0001_2345, 19'd5120);
    random_burst(250);

    drain();
    src_idle_pct = 52;
    snk_idle_pct = 14;
    reconfigure($urandom, 19'($urandom_range(327680, 5120)));
    random_burst(300);
    reconfigure(32'd0, 19'd327679);
    random_burst(250);

    drain();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    reconfigure($urandom, 19'($urandom_range(327680, 5120)));
    random_burst(400);

    drain();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("segregated_free_list_allocator_test: done, clean");
    end else begin
      $display("segregated_free_list_allocator_test: done, errors");
    end
    $finish;
  end

endmodule
